### hw/rtl/mtfe_pkg.sv
// mtfe_pkg: shared types and codes for the move-to-front depth encoder
// no dependencies; imported by the cell, the position encoder and the top level
package mtfe_pkg;

  // request codes on in_req_type
  localparam logic REQ_RESTART = 1'b0;
  localparam logic REQ_ACCESS  = 1'b1;

  localparam int unsigned ITEM_W  = 9;
  localparam int unsigned DEPTH_W = 8;
  localparam logic [DEPTH_W-1:0] DEPTH_SAT = 8'd255;
  localparam logic [ITEM_W-1:0]  COUNT_RST = 9'd256;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_MOVE
  } mtfe_state_t;

  // control broadcast to every cell of the chain
  typedef struct packed {
    logic restart;  // reload the initial order
    logic capture;  // compare the key and latch the match flag
    logic move;     // shift the match and the cells above it down by one
  } mtfe_cell_ctrl_t;

endpackage : mtfe_pkg

### hw/rtl/mtfe_cell.sv
// mtfe_cell: one slot of the ordered stack, holds an id and its match flag
// depends on mtfe_pkg
module mtfe_cell import mtfe_pkg::*; #(
  parameter int unsigned IW    = 9,
  parameter int unsigned CW    = 9,
  parameter int unsigned PW    = 8,
  parameter int unsigned INDEX = 0
) (
  input  logic            clk,
  input  logic            rst_n,
  input  mtfe_cell_ctrl_t ctrl,
  input  logic [CW-1:0]   cmp_key,
  input  logic [PW-1:0]   pos,
  input  logic [IW-1:0]   prev_id,
  output logic [IW-1:0]   id,
  output logic            hit
);

  localparam logic [IW-1:0] INIT_ID = IW'(INDEX + 1);
  localparam logic [PW:0]   IDX     = (PW + 1)'(INDEX);

  logic [IW-1:0] id_r, id_nxt;
  logic          hit_r, hit_nxt;

  always_comb begin
    id_nxt  = id_r;
    hit_nxt = hit_r;
    if (ctrl.restart) begin
      id_nxt = INIT_ID;
    end
    if (ctrl.capture) begin
      hit_nxt = (CW'(id_r) == cmp_key);
    end
    // slots at or above the matching one take their upper neighbour's id
    if (ctrl.move && ({1'b0, pos} >= IDX)) begin
      id_nxt = prev_id;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      id_r <= INIT_ID;
    end else begin
      id_r <= id_nxt;
    end
  end

  always_ff @(posedge clk) begin
    hit_r <= hit_nxt;
  end

  assign id  = id_r;
  assign hit = hit_r;

endmodule : mtfe_cell

### hw/rtl/mtfe_pos_enc.sv
// mtfe_pos_enc: turns the one-hot match flags of the chain into a slot number
// depends on mtfe_pkg
module mtfe_pos_enc import mtfe_pkg::*; #(
  parameter int unsigned N  = 256,
  parameter int unsigned PW = 8
) (
  input  logic [N-1:0]  hit,
  output logic [PW-1:0] pos
);

  always_comb begin
    pos = '0;
    for (int k = 0; k < N; k++) begin
      if (hit[k]) begin
        pos = pos | PW'(k);
      end
    end
  end

endmodule : mtfe_pos_enc

### hw/rtl/move_to_front_depth_encoder.sv
// channel | ports                                  | transfer when
// --------+----------------------------------------+-------------------------
// in      | in_valid in_stall in_req_type in_item  | in_valid && !in_stall
// out     | out_valid out_stall out_depth          | out_valid && !out_stall
//         | out_bad_item                           |
// cfg     | cfg_wr_en cfg_wr_data                  | cfg_wr_en
//
// for an access, all cells first compare in parallel and latch a match flag,
// then the flags are encoded to a slot number and the chain shifts in one pass
// a restart or a flagged access needs no shift; a flagged one waits for a free output
// register, a good one waits to shift while out_valid and out_stall are high
// synchronous active-low reset restores the initial order and item_count of 256
// top level, depends on mtfe_pkg, mtfe_cell and mtfe_pos_enc
module move_to_front_depth_encoder import mtfe_pkg::*; #(
  parameter int unsigned MAX_ITEMS = 256
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic                in_req_type,
  input  logic [ITEM_W-1:0]   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [DEPTH_W-1:0]  out_depth,
  output logic                out_bad_item,
  input  logic                cfg_wr_en,
  input  logic [ITEM_W-1:0]   cfg_wr_data
);

  localparam int unsigned IW = $clog2(MAX_ITEMS + 1);
  localparam int unsigned CW = (IW > ITEM_W) ? IW : ITEM_W;
  localparam int unsigned PW = $clog2(MAX_ITEMS);
  localparam logic [CW-1:0] MAX_ID = CW'(MAX_ITEMS);

  mtfe_state_t      state_r, state_nxt;
  mtfe_cell_ctrl_t  ctrl;
  logic [ITEM_W-1:0]  item_count_r, item_count_nxt;
  logic [IW-1:0]      item_r, item_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [DEPTH_W-1:0] out_depth_r, out_depth_nxt;
  logic               out_bad_item_r, out_bad_item_nxt;

  logic [CW-1:0]      item_ext;
  logic               item_bad;
  logic               out_free;
  logic               in_xfer;
  logic               load_bad;
  logic               load_good;
  logic [IW-1:0]      cell_id [MAX_ITEMS];
  logic [MAX_ITEMS-1:0] hit_vec;
  logic [PW-1:0]      pos_w;
  logic [DEPTH_W-1:0] depth_w;

  assign item_ext = CW'(in_item);
  assign item_bad = (item_ext == '0) || (item_ext > CW'(item_count_r)) || (item_ext > MAX_ID);
  assign out_free = !out_valid_r || !out_stall;
  assign in_xfer  = in_valid && !in_stall;

  // cell chain
  for (genvar k = 0; k < MAX_ITEMS; k++) begin : g_cell
    logic [IW-1:0] prev_id;
    if (k == 0) begin : g_top
      assign prev_id = item_r;
    end else begin : g_rest
      assign prev_id = cell_id[k-1];
    end
    mtfe_cell #(
      .IW    (IW),
      .CW    (CW),
      .PW    (PW),
      .INDEX (k)
    ) u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .ctrl    (ctrl),
      .cmp_key (item_ext),
      .pos     (pos_w),
      .prev_id (prev_id),
      .id      (cell_id[k]),
      .hit     (hit_vec[k])
    );
  end

  mtfe_pos_enc #(
    .N  (MAX_ITEMS),
    .PW (PW)
  ) u_pos_enc (
    .hit (hit_vec),
    .pos (pos_w)
  );

  if (PW > DEPTH_W) begin : g_sat
    assign depth_w = (pos_w > PW'(DEPTH_SAT)) ? DEPTH_SAT : pos_w[DEPTH_W-1:0];
  end else begin : g_nosat
    assign depth_w = DEPTH_W'(pos_w);
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer && (in_req_type == REQ_ACCESS) && !item_bad) begin
          state_nxt = ST_MOVE;
        end
      end
      ST_MOVE: begin
        if (out_free) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control outputs
  always_comb begin
    in_stall  = 1'b1;
    ctrl      = '0;
    load_bad  = 1'b0;
    load_good = 1'b0;
    case (state_r)
      ST_IDLE: begin
        // a flagged access needs the output register at once
        in_stall = (in_req_type == REQ_ACCESS) && item_bad && !out_free;
        if (in_valid && !in_stall) begin
          if (in_req_type == REQ_RESTART) begin
            ctrl.restart = 1'b1;
          end else if (item_bad) begin
            load_bad = 1'b1;
          end else begin
            ctrl.capture = 1'b1;
          end
        end
      end
      ST_MOVE: begin
        if (out_free) begin
          ctrl.move = 1'b1;
          load_good = 1'b1;
        end
      end
      default: in_stall = 1'b1;
    endcase
  end

  // datapath registers
  always_comb begin
    item_count_nxt   = cfg_wr_en ? cfg_wr_data : item_count_r;
    item_nxt         = ctrl.capture ? IW'(item_ext) : item_r;
    out_valid_nxt    = load_bad || load_good || (out_valid_r && out_stall);
    out_depth_nxt    = out_depth_r;
    out_bad_item_nxt = out_bad_item_r;
    if (load_bad) begin
      out_depth_nxt    = '0;
      out_bad_item_nxt = 1'b1;
    end else if (load_good) begin
      out_depth_nxt    = depth_w;
      out_bad_item_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      item_count_r <= COUNT_RST;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      item_count_r <= item_count_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    item_r         <= item_nxt;
    out_depth_r    <= out_depth_nxt;
    out_bad_item_r <= out_bad_item_nxt;
  end

  assign out_valid    = out_valid_r;
  assign out_depth    = out_depth_r;
  assign out_bad_item = out_bad_item_r;

  // a good access always finds its id in exactly one slot
  a_one_match: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MOVE) |-> $onehot(hit_vec))
    else $error("match flags not one-hot during shift");

  // no new transfer while the chain is shifting
  a_busy_stall: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MOVE) |-> in_stall)
    else $error("input taken during shift");

  // the shift cycle delivers an unflagged result
  a_good_result: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_MOVE) && out_free |=> out_valid && !out_bad_item)
    else $error("missing result after shift");

  // a flagged result carries a depth of zero
  a_bad_depth: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_bad_item |-> (out_depth == '0))
    else $error("flagged result with non-zero depth");

endmodule : move_to_front_depth_encoder
